// File: design/kepler_equation_solver_defines.svh
// Assertion macros for the Kepler equation solver
`ifndef KEPLER_EQUATION_SOLVER_DEFINES_SVH
`define KEPLER_EQUATION_SOLVER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define KEQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keq assertion failed");

// next-cycle implication
`define KEQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keq assertion failed");

`endif

// File: design/keq_pkg.sv
// Package: constants, types and tables of the Kepler equation solver
package keq_pkg;
	localparam int ANGLE_BITS = 32;
	localparam int ECC_BITS = 16;
	localparam int CORDIC_STAGES = 30;
	localparam int XY_BITS = 33;
	localparam int PROD_BITS = 2 * XY_BITS;
	localparam int QUO_BITS = 62;

	localparam logic [15:0] ECC_LIMIT = 16'd64880;
	localparam logic [5:0] STEP_CAP = 6'd32;
	localparam logic [XY_BITS-1:0] ONE_Q30 = 33'd1073741824;
	localparam logic [XY_BITS-1:0] CORDIC_START = 33'd652032874;
	localparam logic [XY_BITS-1:0] INV_TWO_PI_Q32 = 33'd683565276;

	localparam logic [1:0] REG_ECC = 2'd0;
	localparam logic [1:0] REG_MAX_ITER = 2'd1;
	localparam logic [1:0] REG_TOL = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_ROT, S_MUL_S, S_MUL_C, S_TERM, S_RES, S_DIV, S_UPD, S_DONE
	} state_t;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};
endpackage

// File: design/kepler_equation_solver.sv
// Top level: Newton-Raphson Kepler solver on a shared CORDIC, multiplier and divider
//
//  channel  | dir | handshake             | payload
//  s_axis   | in  | tvalid/tready         | tdata[31:0] mean_anomaly
//  m_axis   | out | tvalid/tready         | tdata[37:32] steps, [31:0] anomaly; tuser conv
//  cfg      | in  | we, no wait           | index, data
//
// Each Newton step runs 30 CORDIC rotations, three passes through the shared multiplier,
// a residual step, a wait on the bit-serial divider and an update step.
// An item takes at most 32 Newton steps. Input is taken only when idle.
// The finished result sits in an output register; the next request may be accepted
// while it waits. Asynchronous active-low reset, no clearing pass.
`include "kepler_equation_solver_defines.svh"

module kepler_equation_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] mean_anomaly
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] eccentric_anomaly, [37:32] steps_taken, 0
	output logic        m_axis_tuser,   // [0] converged
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import keq_pkg::*;

	state_t state_q, state_d;

	logic [15:0] ecc_cfg_q, tol_cfg_q;
	logic [5:0]  iter_cfg_q;

	logic [15:0]        ecc_q, tol_q;
	logic [5:0]         limit_q, steps_q;
	logic [31:0]        m_q, e_q;
	logic [XY_BITS-1:0] x_q, y_q, z_q;
	logic               flip_q;
	logic [4:0]         stage_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [XY_BITS-1:0] es_q, ec_q;
	logic               rneg_q;
	logic               conv_q;

	logic        out_valid_q, out_conv_q;
	logic [31:0] out_e_q;
	logic [5:0]  out_steps_q;

	logic                 accept, out_free;
	logic signed [XY_BITS-1:0] mul_a, mul_b;
	logic signed [XY_BITS-1:0] xs, ys;
	logic [XY_BITS-1:0]   x_next, y_next, z_next, atan_ext;
	logic [31:0]          load_angle, e_new;
	logic [XY_BITS-1:0]   load_z;
	logic                 load_flip;
	logic                 load_cordic;
	logic [31:0]          e_minus_m;
	logic [XY_BITS-1:0]   diff, term;
	logic [XY_BITS:0]     r_full, d_full;
	logic [31:0]          r_mag, d_val;
	logic                 div_start, div_done;
	logic [QUO_BITS-1:0]  quo;
	logic                 step_conv, last_step;

	keq_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (r_mag),
		.den   (d_val),
		.done  (div_done),
		.quo   (quo)
	);

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_cfg_q  <= '0;
			iter_cfg_q <= 6'd20;
			tol_cfg_q  <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ECC:      ecc_cfg_q  <= cfg_data;
				REG_MAX_ITER: iter_cfg_q <= cfg_data[5:0];
				REG_TOL:      tol_cfg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// CORDIC stage
	assign xs       = x_q;
	assign ys       = y_q;
	assign atan_ext = {1'b0, ATAN_TURNS[stage_q]};
	always_comb begin
		if (!z_q[XY_BITS-1]) begin
			x_next = XY_BITS'(xs - (ys >>> stage_q));
			y_next = XY_BITS'(ys + (xs >>> stage_q));
			z_next = z_q - atan_ext;
		end else begin
			x_next = XY_BITS'(xs + (ys >>> stage_q));
			y_next = XY_BITS'(ys - (xs >>> stage_q));
			z_next = z_q + atan_ext;
		end
	end

	// second and third quarter turns are folded by a half turn
	assign load_angle  = (state_q == S_IDLE) ? s_axis_tdata : e_new;
	assign load_flip   = load_angle[31] ^ load_angle[30];
	assign load_z      = load_flip ? {~load_angle[31], ~load_angle[31], load_angle[30:0]}
	                               : {load_angle[31], load_angle};
	assign load_cordic = accept || (state_q == S_UPD && !last_step);

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_MUL_S: begin
				mul_a = {17'd0, ecc_q};
				mul_b = flip_q ? XY_BITS'(-ys) : ys;
			end
			S_MUL_C: begin
				mul_a = {17'd0, ecc_q};
				mul_b = flip_q ? XY_BITS'(-xs) : xs;
			end
			default: begin
				mul_a = es_q;
				mul_b = INV_TWO_PI_Q32;
			end
		endcase
	end

	// residual and slope
	assign e_minus_m = e_q - m_q;
	assign diff   = {e_minus_m[31], e_minus_m};
	assign term   = prod_q[62:30];
	assign r_full = {diff[XY_BITS-1], diff} - {term[XY_BITS-1], term};
	assign r_mag  = r_full[XY_BITS] ? 32'(-r_full) : r_full[31:0];
	assign d_full = {ONE_Q30[XY_BITS-1], ONE_Q30} - {ec_q[XY_BITS-1], ec_q};
	assign d_val  = (d_full[XY_BITS] || d_full == '0) ? 32'd1 : d_full[31:0];
	assign div_start = (state_q == S_RES);

	assign e_new     = rneg_q ? (e_q + quo[31:0]) : (e_q - quo[31:0]);
	assign step_conv = (quo < {46'd0, tol_q});
	assign last_step = step_conv || ((steps_q + 6'd1) == limit_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_ROT;
			S_ROT:   if (stage_q == 5'(CORDIC_STAGES - 1)) state_d = S_MUL_S;
			S_MUL_S: state_d = S_MUL_C;
			S_MUL_C: state_d = S_TERM;
			S_TERM:  state_d = S_RES;
			S_RES:   state_d = S_DIV;
			S_DIV:   if (div_done) state_d = S_UPD;
			S_UPD:   state_d = last_step ? S_DONE : S_ROT;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			m_q     <= s_axis_tdata;
			e_q     <= s_axis_tdata;
			steps_q <= '0;
			ecc_q   <= (ecc_cfg_q > ECC_LIMIT) ? ECC_LIMIT : ecc_cfg_q;
			tol_q   <= tol_cfg_q;
			if (iter_cfg_q == '0)
				limit_q <= 6'd1;
			else if (iter_cfg_q > STEP_CAP)
				limit_q <= STEP_CAP;
			else
				limit_q <= iter_cfg_q;
		end
		if (load_cordic) begin
			x_q     <= CORDIC_START;
			y_q     <= '0;
			z_q     <= load_z;
			flip_q  <= load_flip;
			stage_q <= '0;
		end else if (state_q == S_ROT) begin
			x_q     <= x_next;
			y_q     <= y_next;
			z_q     <= z_next;
			stage_q <= stage_q + 5'd1;
		end
		if (state_q == S_MUL_S || state_q == S_MUL_C || state_q == S_TERM)
			prod_q <= PROD_BITS'(mul_a * mul_b);
		if (state_q == S_MUL_C)
			es_q <= prod_q[48:16];
		if (state_q == S_TERM)
			ec_q <= prod_q[48:16];
		if (state_q == S_RES)
			rneg_q <= r_full[XY_BITS];
		if (state_q == S_UPD) begin
			e_q     <= e_new;
			steps_q <= steps_q + 6'd1;
			conv_q  <= step_conv;
		end
		if (state_q == S_DONE && out_free) begin
			out_e_q     <= e_q;
			out_steps_q <= steps_q;
			out_conv_q  <= conv_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_steps_q, out_e_q};
	assign m_axis_tuser  = out_conv_q;

	`KEQ_ASSERT_NEXT(a_accept_starts, accept, state_q == S_ROT && stage_q == 5'd0)
	`KEQ_ASSERT_NOW(a_div_in_wait, div_done, state_q == S_DIV)
	`KEQ_ASSERT_NOW(a_steps_range, m_axis_tvalid, out_steps_q != 6'd0 && out_steps_q <= STEP_CAP)
endmodule

// File: design/keq_divider.sv
// Restoring divider, one quotient bit per cycle: quo = (mag << 30) / den
module keq_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [31:0]                  mag,
	input  logic [31:0]                  den,
	output logic                         done,
	output logic [keq_pkg::QUO_BITS-1:0] quo
);
	import keq_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [31:0]         rem_q;
	logic [31:0]         den_q;
	logic [QUO_BITS-1:0] num_q;
	logic [32:0]         trial;
	logic                fits;

	assign trial = {rem_q, num_q[QUO_BITS-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QUO_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			num_q <= {mag, 30'd0};
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q <= {num_q[QUO_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = num_q;
endmodule
